[rtl/core/girt_pkg.sv]
package girt_pkg;

	localparam int unsigned MAX_ENTITIES_DEF = 1024;
	localparam int unsigned CELL_BITS_DEF    = 16;

	localparam int unsigned REQ_W   = 3;
	localparam int unsigned ID_W    = 10;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned CSIZE_W = 31;
	localparam int unsigned RAD_W   = 8;
	localparam int unsigned LRAD_W  = 9;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDAT_W  = 32;

	localparam logic [CSIZE_W-1:0] CELL_SIZE_RST = 31'd262144;
	localparam logic [RAD_W-1:0]   RADIUS_RST    = 8'd2;
	localparam logic [RAD_W-1:0]   MARGIN_RST    = 8'd1;

	localparam logic [CIDX_W-1:0] CFG_CELL_SIZE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_RADIUS    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MARGIN    = 2'd2;

	localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REG    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UPD    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UNREG  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd5;

	typedef struct packed {
		logic in_ready;
		logic capture;
		logic div_start;
		logic div_sel_y;
		logic latch_x;
		logic latch_y;
		logic apply;
		logic clr_wr;
		logic ctr_inc;
		logic walk;
		logic rd_id;
		logic eval_rel;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic             in_valid;
		logic [REQ_W-1:0] req_type;
		logic             div_done;
		logic             ctr_last;
		logic             out_free;
	} status_t;

endpackage

[rtl/core/girt_intf.sv]
interface girt_req_if;
	logic                          valid;
	logic                          ready;
	logic [girt_pkg::REQ_W-1:0]    req_type;
	logic [girt_pkg::ID_W-1:0]     entity_id;
	logic signed [girt_pkg::POS_W-1:0] pos_x;
	logic signed [girt_pkg::POS_W-1:0] pos_y;
	modport source (output valid, req_type, entity_id, pos_x, pos_y, input ready);
	modport sink (input valid, req_type, entity_id, pos_x, pos_y, output ready);
endinterface

interface girt_res_if;
	logic                       valid;
	logic                       ready;
	logic                       relevant;
	logic [girt_pkg::CNT_W-1:0] relevant_count;
	logic                       cell_changed;
	modport source (output valid, relevant, relevant_count, cell_changed, input ready);
	modport sink (input valid, relevant, relevant_count, cell_changed, output ready);
endinterface

interface girt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [girt_pkg::CIDX_W-1:0] index;
	logic [girt_pkg::CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/grid_interest_relevancy_table_core.sv]
// Grid-cell interest table. Requests arrive one per transaction on req and each yields exactly
// one result transaction on res. Client move, register and update map both coordinates to
// cells with one shared 32-step floor divider; a count walks the entity table one entry per cycle
// through its single read port. After reset a clearing pass of one entry per cycle runs before
// the first request is taken; configuration writes on cfg are taken at any time and hold ready
// high.
module grid_interest_relevancy_table_core #(
	parameter int unsigned MAX_ENTITIES = girt_pkg::MAX_ENTITIES_DEF,
	parameter int unsigned CELL_BITS    = girt_pkg::CELL_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	girt_req_if.sink   req,
	girt_res_if.source res,
	girt_cfg_if.sink   cfg
);
	import girt_pkg::*;

	cmd_t    cmd;
	status_t st;

	girt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	girt_dp #(
		.MAX_ENTITIES (MAX_ENTITIES),
		.CELL_BITS    (CELL_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.req    (req),
		.res    (res),
		.cfg    (cfg)
	);

endmodule

[rtl/core/girt_div.sv]
module girt_div #(
	parameter int unsigned CELL_BITS = girt_pkg::CELL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [girt_pkg::POS_W-1:0]     dividend,
	input  logic [girt_pkg::CSIZE_W-1:0]          divisor,
	output logic                                  done,
	output logic signed [CELL_BITS-1:0]           quot_cell
);
	import girt_pkg::*;

	localparam logic signed [33:0] HI = (34'sd1 <<< (CELL_BITS - 1)) - 34'sd1;
	localparam logic signed [33:0] LO = -(34'sd1 <<< (CELL_BITS - 1));

	logic                   busy_q;
	logic                   fin_q;
	logic                   done_q;
	logic [4:0]             cnt_q;
	logic                   neg_q;
	logic [CSIZE_W-1:0]     dsr_q;
	logic [CSIZE_W-1:0]     rem_q;
	logic [POS_W-1:0]       quo_q;
	logic signed [CELL_BITS-1:0] cell_q;

	logic [POS_W-1:0]       mag;
	logic [POS_W-1:0]       sh;
	logic [POS_W-1:0]       dz;
	logic [POS_W-1:0]       diff;
	logic                   ge;
	logic signed [33:0]     qm;
	logic signed [33:0]     qs;

	assign mag  = dividend[POS_W-1] ? (~dividend + 32'd1) : dividend;
	assign sh   = {rem_q, quo_q[POS_W-1]};
	assign dz   = {1'b0, dsr_q};
	assign ge   = sh >= dz;
	assign diff = sh - dz;
	assign qm   = {2'b00, quo_q};
	assign qs   = neg_q ? (-qm - {33'd0, (rem_q != '0)}) : qm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[POS_W-1];
			dsr_q <= (divisor == '0) ? 31'd1 : divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CSIZE_W-1:0] : sh[CSIZE_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
		if (fin_q) begin
			priority if (qs > HI) begin
				cell_q <= HI[CELL_BITS-1:0];
			end else if (qs < LO) begin
				cell_q <= LO[CELL_BITS-1:0];
			end else begin
				cell_q <= qs[CELL_BITS-1:0];
			end
		end
	end

	assign done      = done_q;
	assign quot_cell = cell_q;

endmodule

[rtl/core/girt_ctrl.sv]
module girt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  girt_pkg::status_t st,
	output girt_pkg::cmd_t    cmd
);
	import girt_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT,
		ST_APPLY, ST_QRD, ST_QEVAL, ST_CNT, ST_DRAIN, ST_FIN
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = (state_q == ST_IDLE) && st.in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (st.ctr_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept) begin
						case (st.req_type)
							REQ_MOVE, REQ_REG, REQ_UPD: state_q <= ST_DX_GO;
							REQ_UNREG: state_q <= ST_APPLY;
							REQ_QUERY: state_q <= ST_QRD;
							REQ_COUNT: state_q <= ST_CNT;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_DX_GO:   state_q <= ST_DX_WAIT;
				ST_DX_WAIT: if (st.div_done) state_q <= ST_DY_GO;
				ST_DY_GO:   state_q <= ST_DY_WAIT;
				ST_DY_WAIT: if (st.div_done) state_q <= ST_APPLY;
				ST_APPLY:   state_q <= ST_FIN;
				ST_QRD:     state_q <= ST_QEVAL;
				ST_QEVAL:   state_q <= ST_FIN;
				ST_CNT:     if (st.ctr_last) state_q <= ST_DRAIN;
				ST_DRAIN:   state_q <= ST_FIN;
				ST_FIN:     if (st.out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.in_ready  = (state_q == ST_IDLE);
		cmd.capture   = accept;
		cmd.div_start = (state_q == ST_DX_GO) || (state_q == ST_DY_GO);
		cmd.div_sel_y = (state_q == ST_DY_GO);
		cmd.latch_x   = (state_q == ST_DX_WAIT) && st.div_done;
		cmd.latch_y   = (state_q == ST_DY_WAIT) && st.div_done;
		cmd.apply     = (state_q == ST_APPLY);
		cmd.clr_wr    = (state_q == ST_CLEAR);
		cmd.ctr_inc   = (state_q == ST_CLEAR) || (state_q == ST_CNT);
		cmd.walk      = (state_q == ST_CNT);
		cmd.rd_id     = (state_q == ST_QRD);
		cmd.eval_rel  = (state_q == ST_QEVAL);
		cmd.load_out  = (state_q == ST_FIN) && st.out_free;
	end

endmodule

[rtl/core/girt_dp.sv]
module girt_dp #(
	parameter int unsigned MAX_ENTITIES = girt_pkg::MAX_ENTITIES_DEF,
	parameter int unsigned CELL_BITS    = girt_pkg::CELL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  girt_pkg::cmd_t    cmd,
	output girt_pkg::status_t st,
	girt_req_if.sink          req,
	girt_res_if.source        res,
	girt_cfg_if.sink          cfg
);
	import girt_pkg::*;

	localparam int unsigned TBL   = (MAX_ENTITIES < 1024) ? MAX_ENTITIES : 1024;
	localparam int unsigned AW    = $clog2(TBL);
	localparam int unsigned WW    = 1 + 2 * CELL_BITS;
	localparam int unsigned SUM_W = CELL_BITS + 2;

	logic [CSIZE_W-1:0] cell_size_q;
	logic [RAD_W-1:0]   radius_q;
	logic [RAD_W-1:0]   margin_q;

	logic [REQ_W-1:0]          req_q;
	logic [ID_W-1:0]           id_q;
	logic signed [POS_W-1:0]   px_q;
	logic signed [POS_W-1:0]   py_q;
	logic signed [CELL_BITS-1:0] cell_x_q;
	logic signed [CELL_BITS-1:0] cell_y_q;

	logic signed [CELL_BITS-1:0] client_x_q;
	logic signed [CELL_BITS-1:0] client_y_q;
	logic                        armed_q;
	logic [LRAD_W-1:0]           lrad_q;

	logic [WW-1:0] mem [TBL];
	logic [WW-1:0] rdata_q;
	logic          rd_vld_s1;
	logic [AW-1:0] ctr_q;
	logic [CNT_W-1:0] acc_q;
	logic          res_rel_q;
	logic          res_chg_q;

	logic          out_valid_q;
	logic          out_rel_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic          out_chg_q;

	logic          div_done;
	logic signed [CELL_BITS-1:0] div_cell;
	logic          id_ok;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [WW-1:0] wdata;
	logic          rel_now;
	logic          moved;
	logic          ent_wr;

	function automatic logic rel_f(
		input logic [WW-1:0]           word,
		input logic signed [CELL_BITS-1:0] cx,
		input logic signed [CELL_BITS-1:0] cy,
		input logic                    armed,
		input logic [LRAD_W-1:0]       rad
	);
		logic signed [CELL_BITS-1:0] ex;
		logic signed [CELL_BITS-1:0] ey;
		logic signed [CELL_BITS:0]   dx;
		logic signed [CELL_BITS:0]   dy;
		logic [CELL_BITS:0]          ax;
		logic [CELL_BITS:0]          ay;
		logic [SUM_W-1:0]            sum;
		ex  = word[2*CELL_BITS-1:CELL_BITS];
		ey  = word[CELL_BITS-1:0];
		dx  = {ex[CELL_BITS-1], ex} - {cx[CELL_BITS-1], cx};
		dy  = {ey[CELL_BITS-1], ey} - {cy[CELL_BITS-1], cy};
		ax  = dx[CELL_BITS] ? -dx : dx;
		ay  = dy[CELL_BITS] ? -dy : dy;
		sum = {1'b0, ax} + {1'b0, ay};
		return word[WW-1] && armed && (sum <= SUM_W'(rad));
	endfunction

	girt_div #(.CELL_BITS(CELL_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (cmd.div_sel_y ? py_q : px_q),
		.divisor   (cell_size_q),
		.done      (div_done),
		.quot_cell (div_cell)
	);

	assign id_ok   = 32'(id_q) < MAX_ENTITIES;
	assign rel_now = rel_f(rdata_q, client_x_q, client_y_q, armed_q, lrad_q);
	assign moved   = (cell_x_q != client_x_q) || (cell_y_q != client_y_q);
	assign ent_wr  = (req_q == REQ_REG) || (req_q == REQ_UPD) || (req_q == REQ_UNREG);
	assign we      = cmd.clr_wr || (cmd.apply && ent_wr && id_ok);
	assign waddr   = cmd.clr_wr ? ctr_q : id_q[AW-1:0];
	assign raddr   = cmd.rd_id ? id_q[AW-1:0] : ctr_q;
	assign wdata   = cmd.clr_wr ? '0 : {(req_q != REQ_UNREG), cell_x_q, cell_y_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req.req_type;
			id_q  <= req.entity_id;
			px_q  <= req.pos_x;
			py_q  <= req.pos_y;
		end
		if (cmd.latch_x) begin
			cell_x_q <= div_cell;
		end
		if (cmd.latch_y) begin
			cell_y_q <= div_cell;
		end
		if (cmd.load_out) begin
			out_rel_q <= res_rel_q;
			out_cnt_q <= acc_q;
			out_chg_q <= res_chg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_SIZE_RST;
			radius_q    <= RADIUS_RST;
			margin_q    <= MARGIN_RST;
			client_x_q  <= '0;
			client_y_q  <= '0;
			armed_q     <= 1'b0;
			lrad_q      <= '0;
			ctr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			acc_q       <= '0;
			res_rel_q   <= 1'b0;
			res_chg_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_CELL_SIZE: cell_size_q <= cfg.data[CSIZE_W-1:0];
					CFG_RADIUS:    radius_q    <= cfg.data[RAD_W-1:0];
					CFG_MARGIN:    margin_q    <= cfg.data[RAD_W-1:0];
					default:       ;
				endcase
			end
			if (cmd.ctr_inc) begin
				ctr_q <= st.ctr_last ? '0 : ctr_q + AW'(1);
			end
			rd_vld_s1 <= cmd.walk;
			if (cmd.capture) begin
				acc_q     <= '0;
				res_rel_q <= 1'b0;
				res_chg_q <= 1'b0;
			end else begin
				if (rd_vld_s1 && rel_now) begin
					acc_q <= acc_q + CNT_W'(1);
				end
				if (cmd.eval_rel) begin
					res_rel_q <= id_ok && rel_now;
				end
				if (cmd.apply && (req_q == REQ_MOVE) && moved) begin
					client_x_q <= cell_x_q;
					client_y_q <= cell_y_q;
					armed_q    <= 1'b1;
					lrad_q     <= {1'b0, radius_q} + {1'b0, margin_q};
					res_chg_q  <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.in_valid = req.valid;
	assign st.req_type = req.req_type;
	assign st.div_done = div_done;
	assign st.ctr_last = (ctr_q == AW'(TBL - 1));
	assign st.out_free = !out_valid_q || res.ready;

	assign req.ready          = cmd.in_ready;
	assign cfg.ready          = 1'b1;
	assign res.valid          = out_valid_q;
	assign res.relevant       = out_rel_q;
	assign res.relevant_count = out_cnt_q;
	assign res.cell_changed   = out_chg_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_out && out_valid_q && !res.ready))
		else $error("result overwritten before transaction");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_cnt_q <= CNT_W'(TBL)))
		else $error("count exceeds table depth");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({out_rel_q, out_chg_q, (out_cnt_q != '0)}) <= 1))
		else $error("more than one result field set");
	a_walk_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !rd_vld_s1)
		else $error("result loaded during table walk");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import girt_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
	localparam int N_ENT = MAX_ENTITIES_DEF;
	localparam int CELL_HI = 32767;
	localparam int CELL_LO = -32768;
	localparam int RANDOM_ITEMS = 1720;

	typedef struct packed {
		logic             relevant;
		logic [CNT_W-1:0] relevant_count;
		logic             cell_changed;
	} answer_t;

	typedef struct {
		logic [REQ_W-1:0]        req;
		logic [ID_W-1:0]         id;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		bit                      typed;
		answer_t                 ans;
	} row_t;

	logic clk;
	logic arst_n;

	girt_req_if req ();
	girt_res_if res ();
	girt_cfg_if cfg ();

	grid_interest_relevancy_table_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg(cfg)
	);

	// shadow copy of the block
	logic [CSIZE_W-1:0] cell_size;
	logic [RAD_W-1:0]   radius;
	logic [RAD_W-1:0]   margin;
	int                 client_x;
	int                 client_y;
	bit                 armed;
	logic [LRAD_W-1:0]  reach;
	bit                 present [N_ENT];
	int                 ent_x [N_ENT];
	int                 ent_y [N_ENT];

	answer_t pending_answers[$];
	int      errors;
	int      tx_idle_pct;
	int      rx_idle_pct;
	row_t    directed[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int cell_of(logic signed [POS_W-1:0] p);
		longint pl;
		longint d;
		longint q;
		pl = p;
		d = (cell_size == 0) ? 1 : longint'(cell_size);
		q = pl / d;
		if (pl % d < 0)
			q = q - 1;
		if (q > CELL_HI)
			q = CELL_HI;
		if (q < CELL_LO)
			q = CELL_LO;
		return int'(q);
	endfunction

	function automatic bit in_range(int i);
		longint dx;
		longint dy;
		if (!present[i] || !armed)
			return 1'b0;
		dx = longint'(ent_x[i]) - client_x;
		dy = longint'(ent_y[i]) - client_y;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		return (dx + dy) <= longint'(reach);
	endfunction

	function automatic answer_t serve(logic [REQ_W-1:0] rq, logic [ID_W-1:0] id,
			logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
		answer_t a;
		int cx;
		int cy;
		a = '0;
		case (rq)
			REQ_MOVE: begin
				cx = cell_of(x);
				cy = cell_of(y);
				if (cx != client_x || cy != client_y) begin
					client_x = cx;
					client_y = cy;
					reach = LRAD_W'(radius) + LRAD_W'(margin);
					armed = 1'b1;
					a.cell_changed = 1'b1;
				end
			end
			REQ_REG, REQ_UPD: begin
				ent_x[id] = cell_of(x);
				ent_y[id] = cell_of(y);
				present[id] = 1'b1;
			end
			REQ_UNREG: present[id] = 1'b0;
			REQ_QUERY: a.relevant = in_range(id);
			REQ_COUNT: begin
				for (int i = 0; i < N_ENT; i++)
					if (in_range(i))
						a.relevant_count = a.relevant_count + 1'b1;
			end
			default: a = '0;
		endcase
		return a;
	endfunction

	always @(posedge clk) begin
		res.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_answers.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (res.relevant !== want.relevant) begin
					$error("relevant: expected %0d actual %0d", want.relevant, res.relevant);
					errors++;
				end
				if (res.relevant_count !== want.relevant_count) begin
					$error("relevant_count: expected %0d actual %0d",
						want.relevant_count, res.relevant_count);
					errors++;
				end
				if (res.cell_changed !== want.cell_changed) begin
					$error("cell_changed: expected %0d actual %0d",
						want.cell_changed, res.cell_changed);
					errors++;
				end
			end
		end
	end

	task automatic send(logic [REQ_W-1:0] rq, logic [ID_W-1:0] id,
			logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
			bit typed, answer_t typed_ans);
		answer_t a;
		if ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rq;
		req.entity_id <= id;
		req.pos_x <= x;
		req.pos_y <= y;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		a = serve(rq, id, x, y);
		pending_answers.push_back(typed ? typed_ans : a);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(negedge clk);
		while (!cfg.ready) @(negedge clk);
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_CELL_SIZE: cell_size = val[CSIZE_W-1:0];
			CFG_RADIUS:    radius = val[RAD_W-1:0];
			default:       margin = val[RAD_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic setup(logic [CDAT_W-1:0] cs, logic [RAD_W-1:0] r, logic [RAD_W-1:0] m);
		drain();
		write_reg(CFG_CELL_SIZE, cs);
		write_reg(CFG_RADIUS, {24'd0, r});
		write_reg(CFG_MARGIN, {24'd0, m});
	endtask

	function automatic void add(logic [REQ_W-1:0] rq, logic [ID_W-1:0] id,
			logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
			bit typed, answer_t ans);
		row_t r;
		r.req = rq;
		r.id = id;
		r.x = x;
		r.y = y;
		r.typed = typed;
		r.ans = ans;
		directed.push_back(r);
	endfunction

	function automatic logic signed [POS_W-1:0] near_pos(int centre);
		longint d;
		longint p;
		if ($urandom_range(7) == 0)
			return $urandom;
		d = (cell_size == 0) ? 1 : longint'(cell_size);
		p = (longint'(centre) + longint'($urandom_range(12)) - 64'sd6) * d
			+ longint'($urandom_range(int'(d - 1), 0));
		if (p > 64'sh7fffffff)
			p = 64'sh7fffffff;
		if (p < -64'sh80000000)
			p = -64'sh80000000;
		return POS_W'(p);
	endfunction

	task automatic random_items(int n);
		logic [REQ_W-1:0] rq;
		logic [ID_W-1:0]  id;
		int               pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 14)
				rq = REQ_MOVE;
			else if (pick < 40)
				rq = REQ_REG;
			else if (pick < 52)
				rq = REQ_UPD;
			else if (pick < 62)
				rq = REQ_UNREG;
			else if (pick < 93)
				rq = REQ_QUERY;
			else if (pick < 97)
				rq = REQ_COUNT;
			else
				rq = ($urandom_range(1) != 0) ? REQ_SPARE_A : REQ_SPARE_B;
			id = ($urandom_range(9) < 8) ? ID_W'($urandom_range(31)) : ID_W'($urandom);
			send(rq, id, near_pos(client_x), near_pos(client_y), 1'b0, '0);
		end
	endtask

	initial begin
		answer_t z;
		answer_t chg;
		answer_t hit;
		z = '0;
		chg = '0;
		chg.cell_changed = 1'b1;
		hit = '0;
		hit.relevant = 1'b1;
		errors = 0;
		tx_idle_pct = 8;
		rx_idle_pct = 79;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = '0;
		req.entity_id = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cell_size = CELL_SIZE_RST;
		radius = RADIUS_RST;
		margin = MARGIN_RST;
		client_x = 0;
		client_y = 0;
		armed = 1'b0;
		reach = '0;
		for (int i = 0; i < N_ENT; i++) begin
			present[i] = 1'b0;
			ent_x[i] = 0;
			ent_y[i] = 0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		add(REQ_COUNT, 10'd0, 0, 0, 1'b1, z);
		add(REQ_QUERY, 10'd0, 0, 0, 1'b1, z);
		add(REQ_MOVE, 10'd0, 32'sd5, 32'sd262143, 1'b1, z);
		add(REQ_REG, 10'd0, 0, 0, 1'b1, z);
		add(REQ_QUERY, 10'd0, 0, 0, 1'b1, z);
		add(REQ_MOVE, 10'd0, 32'sd262144, 0, 1'b1, chg);
		add(REQ_QUERY, 10'd0, 0, 0, 1'b1, hit);
		add(REQ_REG, 10'd1023, 32'sh7fffffff, 32'sh7fffffff, 1'b0, z);
		add(REQ_REG, 10'd5, 32'sh80000000, 32'sh80000000, 1'b0, z);
		add(REQ_UPD, 10'd6, -32'sd1, 32'sd524288, 1'b0, z);
		add(REQ_REG, 10'd0, 32'sd3000000, -32'sd900000, 1'b0, z);
		add(REQ_QUERY, 10'd0, 0, 0, 1'b0, z);
		add(REQ_UNREG, 10'd7, 0, 0, 1'b0, z);
		add(REQ_UNREG, 10'd6, 0, 0, 1'b0, z);
		add(REQ_QUERY, 10'd6, 0, 0, 1'b1, z);
		add(REQ_QUERY, 10'd1023, 0, 0, 1'b0, z);
		add(REQ_COUNT, 10'd0, 0, 0, 1'b0, z);
		add(REQ_SPARE_A, 10'd3, 32'sd1, 32'sd1, 1'b1, z);
		add(REQ_SPARE_B, 10'h3ff, -32'sd1, -32'sd1, 1'b1, z);
		add(REQ_MOVE, 10'd0, -32'sd1, -32'sd1, 1'b1, chg);
		add(REQ_MOVE, 10'd0, -32'sd2, -32'sd262144, 1'b1, z);
		add(REQ_COUNT, 10'd0, 0, 0, 1'b0, z);
		foreach (directed[i])
			send(directed[i].req, directed[i].id, directed[i].x, directed[i].y,
				directed[i].typed, directed[i].ans);

		// saturating cells at the smallest cell size, widest reach
		setup(32'd1, 8'd255, 8'd255);
		send(REQ_MOVE, 10'd0, 32'sh7fffffff, 32'sh80000000, 1'b0, '0);
		send(REQ_REG, 10'd2, 32'sd40000, -32'sd40000, 1'b0, '0);
		send(REQ_QUERY, 10'd2, 0, 0, 1'b0, '0);
		random_items(RANDOM_ITEMS / 5);

		setup(32'h7fffffff, 8'd0, 8'd0);
		random_items(RANDOM_ITEMS / 5);

		tx_idle_pct = 79;
		rx_idle_pct = 8;
		setup(32'd0, 8'd1, 8'd0);
		random_items(RANDOM_ITEMS / 5);

		setup(32'd4096, 8'd5, 8'd2);
		random_items(RANDOM_ITEMS / 5);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		setup(32'hffffffff, 8'd3, 8'd255);
		setup(32'd262144, 8'd2, 8'd1);
		random_items(RANDOM_ITEMS / 5);

		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
